>>> design/sfr_pkg.sv
package sfr_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] REG_SEARCH_PATTERN  = 3'd0;
    localparam logic [2:0] REG_SEARCH_LENGTH   = 3'd1;
    localparam logic [2:0] REG_REPLACE_PATTERN = 3'd2;
    localparam logic [2:0] REG_REPLACE_LENGTH  = 3'd3;
    localparam logic [2:0] REG_CAPACITY        = 3'd4;

    typedef struct packed {
        logic [63:0] search_pattern;
        logic [3:0]  search_length;
        logic [63:0] replace_pattern;
        logic [3:0]  replace_length;
        logic [31:0] capacity;
    } sfr_cfg_t;

    // one output word on its way from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } sfr_word_t;

endpackage

>>> design/sfr_front.sv
module sfr_front #(
    parameter int MAX_PATTERN = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sfr_pkg::sfr_cfg_t cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    output logic             q_push,
    output sfr_pkg::sfr_word_t q_word,
    input  logic             q_full
);
    import sfr_pkg::*;

    localparam int WIN_W  = MAX_PATTERN * 8;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MAIN  = 2'd1;
    localparam logic [1:0] PH_REPL  = 2'd2;
    localparam logic [1:0] PH_FLUSH = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  rep_idx_reg, rep_idx_next;
    logic [7:0]        hold_byte_reg, hold_byte_next;
    logic              hold_eos_reg, hold_eos_next;
    logic              emitted_reg, emitted_next;

    logic [FILL_W-1:0] slen, rlen;
    logic [7:0]        cur_byte;
    logic              cur_eos;
    logic              adv;
    logic              evict;
    logic [WIN_W-1:0]  win_sh, new_win;
    logic [FILL_W-1:0] fill_sh, new_fill;
    logic              lanes_eq;
    logic              is_match;
    logic              done;
    logic              work;
    logic              pushed;

    assign slen = (cfg.search_length > 4'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                        : FILL_W'(cfg.search_length);
    assign rlen = (cfg.replace_length > 4'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                         : FILL_W'(cfg.replace_length);

    assign cur_byte = (phase_reg == PH_IDLE) ? s_tdata : hold_byte_reg;
    assign cur_eos  = (phase_reg == PH_IDLE) ? s_tlast : hold_eos_reg;
    assign adv      = !q_full;

    assign evict   = (fill_reg == slen);
    assign win_sh  = evict ? (win_reg >> 8) : win_reg;
    assign fill_sh = fill_reg - FILL_W'(evict);
    assign new_fill = fill_sh + FILL_W'(1);

    always_comb begin
        lanes_eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            new_win[i*8 +: 8] = (FILL_W'(i) == fill_sh) ? cur_byte : win_sh[i*8 +: 8];
            if ((FILL_W'(i) < slen) && (new_win[i*8 +: 8] != cfg.search_pattern[i*8 +: 8])) begin
                lanes_eq = 1'b0;
            end
        end
    end

    assign is_match = (new_fill == slen) && lanes_eq;

    always_comb begin
        phase_next     = phase_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        rep_idx_next   = rep_idx_reg;
        hold_byte_next = hold_byte_reg;
        hold_eos_next  = hold_eos_reg;
        q_push         = 1'b0;
        q_word         = '0;
        done           = 1'b0;
        work           = 1'b0;
        pushed         = 1'b0;

        unique case (phase_reg)
            PH_IDLE, PH_MAIN: begin
                work = (phase_reg == PH_MAIN) ? adv : (s_tvalid && adv);
                if (work) begin
                    if (slen == '0) begin
                        if (fill_reg != '0) begin
                            q_push       = 1'b1;
                            q_word.data  = win_reg[7:0];
                            q_word.valid = 1'b1;
                            win_next     = win_reg >> 8;
                            fill_next    = fill_reg - FILL_W'(1);
                            phase_next   = PH_MAIN;
                        end else begin
                            q_push       = 1'b1;
                            q_word.data  = cur_byte;
                            q_word.valid = 1'b1;
                            q_word.last  = cur_eos;
                            done         = 1'b1;
                        end
                    end else if (fill_reg > slen) begin
                        q_push       = 1'b1;
                        q_word.data  = win_reg[7:0];
                        q_word.valid = 1'b1;
                        win_next     = win_reg >> 8;
                        fill_next    = fill_reg - FILL_W'(1);
                        phase_next   = PH_MAIN;
                    end else begin
                        if (evict) begin
                            q_push       = 1'b1;
                            q_word.data  = win_reg[7:0];
                            q_word.valid = 1'b1;
                            q_word.last  = cur_eos && is_match && (rlen == '0);
                        end
                        if (is_match) begin
                            win_next  = '0;
                            fill_next = '0;
                            if (rlen != '0) begin
                                phase_next   = PH_REPL;
                                rep_idx_next = '0;
                            end else if (cur_eos && !((phase_reg == PH_MAIN && emitted_reg)
                                                      || evict)) begin
                                phase_next = PH_FLUSH;
                            end else begin
                                done = 1'b1;
                            end
                        end else begin
                            win_next  = new_win;
                            fill_next = new_fill;
                            if (cur_eos) begin
                                phase_next = PH_FLUSH;
                            end else begin
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            PH_REPL: begin
                if (adv) begin
                    q_push       = 1'b1;
                    q_word.data  = cfg.replace_pattern[rep_idx_reg*8 +: 8];
                    q_word.valid = 1'b1;
                    q_word.last  = hold_eos_reg
                                   && (FILL_W'(rep_idx_reg) + FILL_W'(1) == rlen);
                    rep_idx_next = rep_idx_reg + IDX_W'(1);
                    if (FILL_W'(rep_idx_reg) + FILL_W'(1) == rlen) begin
                        done = 1'b1;
                    end
                end
            end
            PH_FLUSH: begin
                if (adv) begin
                    q_push = 1'b1;
                    if (fill_reg == '0) begin
                        q_word.last = 1'b1;
                        done        = 1'b1;
                    end else begin
                        q_word.data  = win_reg[7:0];
                        q_word.valid = 1'b1;
                        q_word.last  = (fill_reg == FILL_W'(1));
                        win_next     = win_reg >> 8;
                        fill_next    = fill_reg - FILL_W'(1);
                        if (fill_reg == FILL_W'(1)) begin
                            done = 1'b1;
                        end
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        pushed   = q_push;
        s_tready = (phase_reg == PH_IDLE) ? adv : (done && adv);

        if (s_tvalid && s_tready) begin
            hold_byte_next = s_tdata;
            hold_eos_next  = s_tlast;
        end

        emitted_next = ((phase_reg == PH_MAIN) && emitted_reg) || pushed;

        if (done) begin
            if (phase_reg != PH_IDLE && s_tvalid) begin
                phase_next   = PH_MAIN;
                emitted_next = 1'b0;
            end else begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            win_reg     <= '0;
            fill_reg    <= '0;
            rep_idx_reg <= '0;
            emitted_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            rep_idx_reg <= rep_idx_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_byte_reg <= hold_byte_next;
        hold_eos_reg  <= hold_eos_next;
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("word pushed into a full queue");

    a_repl_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_REPL) |-> (fill_reg == '0))
        else $error("window not cleared during replacement");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_PATTERN))
        else $error("window overfilled");

endmodule

>>> design/sfr_fifo.sv
module sfr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sfr_pkg::sfr_word_t push_word,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output sfr_pkg::sfr_word_t head_word
);
    import sfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_word_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> design/sfr_back.sv
module sfr_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [31:0]        capacity,
    input  logic               q_valid,
    input  sfr_pkg::sfr_word_t q_word,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);
    import sfr_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_sat;
    logic                   m_valid_reg, m_valid_next;
    sfr_word_t              m_word_reg, m_word_next;
    logic                   ovf_reg, ovf_next;
    logic                   load;

    assign load  = q_valid && (!m_valid_reg || m_tready);
    assign q_pop = load;

    // saturating count of data bytes including the one being loaded
    assign count_sat = (!q_word.valid || (&count_reg)) ? count_reg
                                                       : count_reg + COUNT_WIDTH'(1);

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        ovf_next     = ovf_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            m_word_next  = q_word;
            ovf_next     = q_word.last && (CMP_W'(count_sat) >= CMP_W'(capacity));
            count_next   = q_word.last ? '0 : count_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        ovf_reg    <= ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg.data;
    assign m_tlast  = m_word_reg.last;
    assign m_tuser  = {ovf_reg, m_word_reg.valid};

    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && q_word.last) |=> (count_reg == '0))
        else $error("byte count not cleared after last word");

    a_ovf_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ovf_reg) |-> m_word_reg.last)
        else $error("overflow flag on a word that is not last");

endmodule

>>> design/stream_find_replace_top.sv
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata=in_byte, s_tlast=end_of_string
// m_       out  m_tvalid/m_tready  m_tdata=out_byte, m_tlast=last, m_tuser=byte_valid,overflow
// cfg_     in   cfg_wr_en          cfg_index selects register, cfg_data value
//
// One input word per cycle while the match window is steady and the queue has room;
// a match holds the input while the replacement bytes go out, a shrunk search length
// while the extra held bytes go out, and end of string while the window drains or a bare end marker goes out.
// The front sequencer emits at most one output word per cycle into a 4-deep queue.
// Results are registered in the queue and then in the output register before they appear.
// Synchronous active-low reset clears window, queue, counters and config (capacity resets to all ones).
// Either side may stall at any time; a stalled output backs up through the queue.
module stream_find_replace_top #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // byte_valid, overflow
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import sfr_pkg::*;

    sfr_cfg_t  cfg_reg, cfg_next;
    logic      q_push, q_full, q_pop, q_valid;
    sfr_word_t q_in_word, q_head_word;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SEARCH_PATTERN:  cfg_next.search_pattern  = cfg_data;
                REG_SEARCH_LENGTH:   cfg_next.search_length   = cfg_data[3:0];
                REG_REPLACE_PATTERN: cfg_next.replace_pattern = cfg_data;
                REG_REPLACE_LENGTH:  cfg_next.replace_length  = cfg_data[3:0];
                REG_CAPACITY:        cfg_next.capacity        = cfg_data[31:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.search_pattern  <= '0;
            cfg_reg.search_length   <= '0;
            cfg_reg.replace_pattern <= '0;
            cfg_reg.replace_length  <= '0;
            cfg_reg.capacity        <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfr_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_word   (q_in_word),
        .q_full   (q_full)
    );

    sfr_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_word  (q_in_word),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_word  (q_head_word)
    );

    sfr_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (cfg_reg.capacity),
        .q_valid  (q_valid),
        .q_word   (q_head_word),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> test/stream_find_replace_top_tb.sv
`timescale 1ns / 100ps

module stream_find_replace_top_tb;
    import sfr_pkg::*;

    localparam int          MAX_LEN       = 8;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          MODE_WORDS    = 48;
    localparam logic [2:0]  REG_UNUSED    = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic       ovf;
    } out_word_t;

    typedef enum logic [1:0] {ROW_REG, ROW_WORD, ROW_TYPED} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] value;
        logic [7:0]  b;
        logic        eos;
        out_word_t   want;
    } plan_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // in_byte
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // out_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;           // byte_valid, overflow
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    stream_find_replace_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow registers and window state
    logic [63:0] pat       = '0;
    logic [3:0]  pat_len   = '0;
    logic [63:0] rep       = '0;
    logic [3:0]  rep_len   = '0;
    logic [31:0] cap_bytes = 32'hFFFF_FFFF;
    logic [63:0] win_bytes = '0;
    logic [3:0]  win_fill  = '0;
    logic [31:0] out_count = '0;

    out_word_t step_words[$];
    out_word_t words_due[$];
    plan_row_t plan[$];

    int  send_pct  = 0;
    int  recv_pct  = 0;
    int  errors    = 0;
    int  words_in  = 0;
    int  words_out = 0;
    int  setups    = 0;
    int  quiet     = 0;
    bit  dirty     = 0;

    function automatic int clamp_len(input logic [3:0] n);
        return (n > MAX_LEN) ? MAX_LEN : int'(n);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        step_words.push_back('{b, 1'b1, 1'b0, 1'b0});
        if (out_count != 32'hFFFF_FFFF) out_count++;
    endfunction

    function automatic void shift_out();
        put_byte(win_bytes[7:0]);
        win_bytes = win_bytes >> 8;
        win_fill--;
    endfunction

    function automatic void rewrite_byte(input logic [7:0] b, input logic eos);
        int          slen;
        int          rlen;
        logic [63:0] mask;
        out_word_t   w;
        step_words.delete();
        slen = clamp_len(pat_len);
        rlen = clamp_len(rep_len);
        if (slen == 0) begin
            while (win_fill > 0) shift_out();
            put_byte(b);
        end else begin
            while (int'(win_fill) >= slen) shift_out();
            win_bytes = win_bytes | (64'(b) << (win_fill * 8));
            win_fill++;
            mask = (slen >= 8) ? '1 : ((64'd1 << (slen * 8)) - 64'd1);
            if (int'(win_fill) == slen && ((win_bytes ^ pat) & mask) == '0) begin
                for (int i = 0; i < rlen; i++) put_byte(rep[i*8 +: 8]);
                win_bytes = '0;
                win_fill  = '0;
            end
        end
        if (eos) begin
            while (win_fill > 0) shift_out();
            if (step_words.size() == 0) step_words.push_back('0);
            w      = step_words[step_words.size() - 1];
            w.last = 1'b1;
            w.ovf  = ({1'b0, out_count} + 33'd1) > {1'b0, cap_bytes};
            step_words[step_words.size() - 1] = w;
            win_bytes = '0;
            win_fill  = '0;
            out_count = '0;
        end
    endfunction

    // result side: stall, compare
    always @(posedge aclk) begin
        out_word_t got;
        out_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
                words_out++;
                if (words_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word data %h byte %b last %b ovf %b", $time,
                             got.data, got.has_byte, got.last, got.ovf);
                end else begin
                    want = words_due.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected data %h byte %b last %b ovf %b, got data %h byte %b last %b ovf %b",
                                 $time, want.data, want.has_byte, want.last, want.ovf,
                                 got.data, got.has_byte, got.last, got.ovf);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet <= 0;
            end else begin
                quiet <= quiet + 1;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no progress, %0d words still due", $time, words_due.size());
                $display("stream_find_replace_top_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic settle();
        s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        dirty = 0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        if (dirty) settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SEARCH_PATTERN:  pat       = value;
            REG_SEARCH_LENGTH:   pat_len   = value[3:0];
            REG_REPLACE_PATTERN: rep       = value;
            REG_REPLACE_LENGTH:  rep_len   = value[3:0];
            REG_CAPACITY:        cap_bytes = value[31:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_word(input logic [7:0] b, input logic eos, input logic typed,
                             input out_word_t want);
        if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rewrite_byte(b, eos);
        if (typed) begin
            words_due.push_back(want);
        end else begin
            foreach (step_words[i]) words_due.push_back(step_words[i]);
        end
        words_in++;
        dirty = 1;
    endtask

    task automatic pick_setup();
        logic [63:0] p;
        logic [7:0]  fill;
        logic [3:0]  slen;
        logic [3:0]  rlen;
        logic [31:0] c;
        p = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: begin
                fill = 8'($urandom_range(0, 255));
                p = {8{fill}};
            end
            1: for (int i = 0; i < 8; i++) p[i*8 +: 8] = 8'h61 + 8'($urandom_range(0, 1));
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0:       slen = 4'd0;
            1:       slen = 4'd8;
            2:       slen = 4'($urandom_range(9, 15));
            default: slen = 4'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       rlen = 4'd0;
            1:       rlen = 4'd8;
            2:       rlen = 4'd15;
            default: rlen = 4'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       c = 32'd0;
            1:       c = 32'd1;
            2:       c = $urandom_range(2, 30);
            3:       c = $urandom;
            default: c = 32'hFFFF_FFFF;
        endcase
        write_reg(REG_SEARCH_PATTERN, p);
        write_reg(REG_SEARCH_LENGTH, {60'd0, slen});
        write_reg(REG_REPLACE_PATTERN, {$urandom, $urandom});
        write_reg(REG_REPLACE_LENGTH, {60'd0, rlen});
        write_reg(REG_CAPACITY, {32'd0, c});
        setups++;
    endtask

    // strings built mostly from whole or partial copies of the search pattern
    task automatic send_string();
        logic [7:0] text[$];
        int         plen;
        int         len;
        int         cut;
        plen = clamp_len(pat_len);
        len  = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
        while (text.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: for (int j = 0; j < plen; j++) text.push_back(pat[j*8 +: 8]);
                4: if (plen > 1) begin
                    cut = $urandom_range(1, plen - 1);
                    for (int j = 0; j < cut; j++) text.push_back(pat[j*8 +: 8]);
                end
                5, 6: if (plen > 0) text.push_back(pat[$urandom_range(0, plen - 1)*8 +: 8]);
                default: text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        foreach (text[i]) send_word(text[i], i == text.size() - 1, 1'b0, '0);
    endtask

    function automatic void add_reg(input logic [2:0] idx, input logic [63:0] value);
        plan.push_back('{ROW_REG, idx, value, 8'h00, 1'b0, '0});
    endfunction

    function automatic void add_word(input logic [7:0] b, input logic eos);
        plan.push_back('{ROW_WORD, 3'd0, 64'd0, b, eos, '0});
    endfunction

    function automatic void add_typed(input logic [7:0] b, input logic eos,
                                      input out_word_t want);
        plan.push_back('{ROW_TYPED, 3'd0, 64'd0, b, eos, want});
    endfunction

    initial begin
        int mode_start;

        // pass-through after reset
        add_typed(8'h00, 1'b0, '{8'h00, 1'b1, 1'b0, 1'b0});
        add_typed(8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0});
        add_typed(8'h5A, 1'b1, '{8'h5A, 1'b1, 1'b1, 1'b0});
        // tiny buffers overflow
        add_reg(REG_CAPACITY, 64'd1);
        add_typed(8'h11, 1'b1, '{8'h11, 1'b1, 1'b1, 1'b1});
        add_reg(REG_CAPACITY, 64'd0);
        add_typed(8'h22, 1'b1, '{8'h22, 1'b1, 1'b1, 1'b1});
        add_reg(REG_UNUSED, '1);
        add_reg(REG_CAPACITY, 64'hFFFF_FFFF);
        // delete a single char: bare end marker
        add_reg(REG_SEARCH_PATTERN, 64'h41);
        add_reg(REG_SEARCH_LENGTH, 64'd1);
        add_reg(REG_REPLACE_LENGTH, 64'd0);
        add_typed(8'h41, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0});
        // "abc" -> "XYZW", includes a restart on a partial match
        add_reg(REG_SEARCH_PATTERN, 64'h0063_6261);
        add_reg(REG_SEARCH_LENGTH, 64'd3);
        add_reg(REG_REPLACE_PATTERN, 64'h575A_5958);
        add_reg(REG_REPLACE_LENGTH, 64'd4);
        add_word(8'h61, 1'b0);
        add_word(8'h62, 1'b0);
        add_word(8'h63, 1'b0);
        add_word(8'h61, 1'b0);
        add_word(8'h61, 1'b0);
        add_word(8'h62, 1'b0);
        add_word(8'h63, 1'b0);
        add_word(8'h64, 1'b1);
        // lengths above 8 saturate
        add_reg(REG_SEARCH_PATTERN, '1);
        add_reg(REG_SEARCH_LENGTH, 64'd15);
        add_reg(REG_REPLACE_PATTERN, 64'h0123_4567_89AB_CDEF);
        add_reg(REG_REPLACE_LENGTH, 64'd15);
        for (int i = 0; i < 8; i++) add_word(8'hFF, i == 7);
        // search length shrunk with bytes held
        add_reg(REG_SEARCH_PATTERN, 64'd0);
        add_word(8'h10, 1'b0);
        add_word(8'h20, 1'b0);
        add_word(8'h30, 1'b0);
        add_reg(REG_SEARCH_LENGTH, 64'd2);
        add_word(8'h40, 1'b1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_REG:   write_reg(plan[i].idx, plan[i].value);
                ROW_WORD:  send_word(plan[i].b, plan[i].eos, 1'b0, '0);
                ROW_TYPED: send_word(plan[i].b, plan[i].eos, 1'b1, plan[i].want);
                default: ;
            endcase
        end

        // no idling, sender idle, receiver stall, both
        for (int m = 0; m < 4; m++) begin
            send_pct = (m == 1) ? 79 : (m == 3) ? 21 : 0;
            recv_pct = (m == 2) ? 79 : (m == 3) ? 21 : 0;
            mode_start = words_in;
            while (words_in - mode_start < MODE_WORDS) begin
                pick_setup();
                repeat (3) send_string();
            end
        end

        settle();
        $display("%0d input words over %0d random register setups, %0d result words checked",
                 words_in, setups, words_out);
        $display("idling: none, sender only, receiver only, both; %0d errors", errors);
        if (errors == 0 && words_due.size() == 0) begin
            $display("stream_find_replace_top_tb: PASS");
        end else begin
            $display("stream_find_replace_top_tb: FAIL");
        end
        $finish;
    end

endmodule
